// ----- rtl/scta_pkg.sv -----
`timescale 1ns / 1ps

package scta_pkg;

  localparam int unsigned PLANE_SIZE = 84;
  localparam int unsigned IDX_W      = $clog2(PLANE_SIZE);

  localparam logic [7:0] KEYPAD_LO      = 8'h47;
  localparam logic [7:0] KEYPAD_END     = 8'h54;
  localparam logic [7:0] CODE_CAPS      = 8'h3A;
  localparam logic [7:0] CODE_LSHIFT    = 8'h2A;
  localparam logic [7:0] CODE_RSHIFT    = 8'h36;
  localparam logic [7:0] CODE_NUM       = 8'h45;
  localparam logic [7:0] CODE_LSHIFT_UP = 8'hAA;
  localparam logic [7:0] CODE_RSHIFT_UP = 8'hB6;
  localparam int unsigned RELEASE_BIT   = 7;

  localparam logic [6:0] PRINT_LO  = 7'h20;
  localparam logic [6:0] CHAR_DEL  = 7'h7F;

  typedef struct packed {
    logic num_lock;
    logic caps_lock;
    logic shift;
  } mod_flags_t;

  typedef logic [6:0] char_t;
  typedef logic [IDX_W-1:0] rom_idx_t;

  // planes: normal, caps, shift, caps with shift
  localparam char_t CHAR_ROM [4][PLANE_SIZE] = '{
    '{7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
      7'h2D, 7'h3D, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
      7'h6A, 7'h6B, 7'h6C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
      7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30, 7'h2E},
    '{7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
      7'h2D, 7'h3D, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h5B, 7'h5D, 7'h0D, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
      7'h4A, 7'h4B, 7'h4C, 7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
      7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30, 7'h2E},
    '{7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
      7'h5F, 7'h2B, 7'h08, 7'h09, 7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
      7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48,
      7'h4A, 7'h4B, 7'h4C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
      7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
      7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30, 7'h2E},
    '{7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
      7'h5F, 7'h2B, 7'h08, 7'h09, 7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
      7'h6F, 7'h70, 7'h7B, 7'h7D, 7'h0D, 7'h00, 7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68,
      7'h6A, 7'h6B, 7'h6C, 7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C, 7'h7A, 7'h78, 7'h63, 7'h76,
      7'h62, 7'h6E, 7'h6D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20, 7'h00, 7'h00,
      7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
      7'h38, 7'h39, 7'h2D, 7'h34, 7'h35, 7'h36, 7'h2B, 7'h31, 7'h32, 7'h33, 7'h30, 7'h2E}
  };

endpackage

// ----- rtl/scta_flags.sv -----
`timescale 1ns / 1ps

module scta_flags (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic [7:0]              scan_code,
  output scta_pkg::mod_flags_t    flags,
  output scta_pkg::mod_flags_t    flags_next
);

  always_comb begin
    flags_next = flags;
    if (!scan_code[scta_pkg::RELEASE_BIT]) begin
      if (scan_code == scta_pkg::CODE_CAPS) begin
        flags_next.caps_lock = !flags.caps_lock;
      end else if (scan_code == scta_pkg::CODE_LSHIFT || scan_code == scta_pkg::CODE_RSHIFT) begin
        flags_next.shift = 1'b1;
      end else if (scan_code == scta_pkg::CODE_NUM) begin
        flags_next.num_lock = !flags.num_lock;
      end
    end else if (scan_code == scta_pkg::CODE_LSHIFT_UP ||
                 scan_code == scta_pkg::CODE_RSHIFT_UP) begin
      flags_next.shift = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '{num_lock: 1'b1, caps_lock: 1'b0, shift: 1'b0};
    end else if (accept) begin
      flags <= flags_next;
    end
  end

endmodule

// ----- rtl/scta_lookup.sv -----
`timescale 1ns / 1ps

module scta_lookup (
  input  logic                 hit,
  input  scta_pkg::rom_idx_t   idx,
  input  logic                 caps_lock,
  input  logic                 shift,
  output scta_pkg::char_t      ascii_char,
  output logic                 printable
);

  scta_pkg::char_t rom_data;

  always_comb begin
    rom_data   = scta_pkg::CHAR_ROM[{shift, caps_lock}][idx];
    ascii_char = hit ? rom_data : '0;
    printable  = (ascii_char >= scta_pkg::PRINT_LO) && (ascii_char != scta_pkg::CHAR_DEL);
  end

endmodule

// ----- rtl/scancode_to_ascii_translator.sv -----
`timescale 1ns / 1ps

// Set-1 scan code to ASCII translator. One scan byte is taken and one result
// leaves per item, registered in the s1 stage and then the output register;
// a new item can be taken every cycle while the output is not stalled. The
// shift, caps-lock and num-lock flags are updated in the same cycle an item
// is accepted, so the flag register loop sets the one-item-per-cycle rate.
// The character table is chosen by the flags as they stood before the item;
// modifier_flags show the flags after it. Num lock is on after reset.
module scancode_to_ascii_translator (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] scan_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [6:0] ascii_char,
  output logic       printable,
  output logic [2:0] modifier_flags
);

  logic                 accept;
  logic                 s1_ready;
  scta_pkg::mod_flags_t flags;
  scta_pkg::mod_flags_t flags_next;
  logic                 hit_next;

  logic                 s1_valid;
  logic                 s1_hit;
  scta_pkg::rom_idx_t   s1_idx;
  scta_pkg::mod_flags_t s1_old;
  scta_pkg::mod_flags_t s1_new;

  scta_pkg::char_t      lk_char;
  logic                 lk_printable;

  assign s1_ready = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_ready;
  assign accept   = in_valid && in_ready;

  // make code below keypad, or keypad with num lock on
  assign hit_next = !scan_code[scta_pkg::RELEASE_BIT] &&
                    ((scan_code < scta_pkg::KEYPAD_LO) ||
                     ((scan_code < scta_pkg::KEYPAD_END) && flags.num_lock));

  scta_flags u_flags (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .scan_code  (scan_code),
    .flags      (flags),
    .flags_next (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_hit <= hit_next;
      s1_idx <= scan_code[scta_pkg::IDX_W-1:0];
      s1_old <= flags;
      s1_new <= flags_next;
    end
  end

  scta_lookup u_lookup (
    .hit        (s1_hit),
    .idx        (s1_idx),
    .caps_lock  (s1_old.caps_lock),
    .shift      (s1_old.shift),
    .ascii_char (lk_char),
    .printable  (lk_printable)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && s1_valid) begin
      ascii_char     <= lk_char;
      printable      <= lk_printable;
      modifier_flags <= s1_new;
    end
  end

endmodule

// ----- rtl/scta_checker.sv -----
`timescale 1ns / 1ps

module scta_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] scan_code,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] ascii_char,
  input logic       printable,
  input logic [2:0] modifier_flags
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ascii_char) &&
    $stable(printable) && $stable(modifier_flags))
    else $error("stalled result changed");

  a_printable: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> printable == ((ascii_char >= 7'h20) && (ascii_char != 7'h7F)))
    else $error("printable flag disagrees with character");

  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input held off without an output stall");

endmodule

bind scancode_to_ascii_translator scta_checker u_checker (.*);
